[src/v3alu_pkg.sv]
// ----------------------------------------------------------------------------
// Vector ALU package
// Request and response payload types, operation codes and status codes of
// the three-component fixed-point vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_SUB       = 3'd1;
   localparam logic [2:0] OP_DOT       = 3'd2;
   localparam logic [2:0] OP_SCALE     = 3'd3;
   localparam logic [2:0] OP_CROSS     = 3'd4;
   localparam logic [2:0] OP_LENGTH    = 3'd5;
   localparam logic [2:0] OP_NORMALIZE = 3'd6;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SAT      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale_factor;
   } v3alu_req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_scalar;
      logic [1:0]         status;
   } v3alu_rsp_type;

endpackage

[src/vec3_fixed_point_alu_unit.sv]
// ----------------------------------------------------------------------------
// Three-component fixed-point vector ALU
// Add, subtract, dot, scale, cross, length and normalize on signed vectors
// with FRAC_BITS fractional bits, with saturation and status reporting.
// ----------------------------------------------------------------------------
// The unit accepts one request per cycle while the output is not held and
// returns one response per request in order. The square root resolves one
// root bit per stage over 32 stages, and the divider for normalize resolves
// one quotient bit per stage over FRAC_BITS + 1 stages; every operation
// travels the same pipeline. When the response is not taken, the whole
// pipeline holds and request ready drops.
module vec3_fixed_point_alu_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  v3alu_pkg::v3alu_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output v3alu_pkg::v3alu_rsp_type rsp_data
);

   localparam int QW = FRAC_BITS + 1;
   localparam int NW = 33 + FRAC_BITS;
   localparam int SQ_STEPS = 32;
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] MAX66 = 66'sd2147483647;
   localparam logic signed [65:0] MIN66 = -66'sd2147483648;

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] rs;
      logic               sat;
   } carry_type;

   function automatic logic [32:0] sat_word(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > MAX66) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < MIN66) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic adv;
   logic out_valid_ff;
   v3alu_pkg::v3alu_rsp_type out_ff;

   assign adv = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // Input register.
   logic in_valid_ff;
   v3alu_pkg::v3alu_req_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
      if (adv) begin
         in_ff <= req_data;
      end
   end

   // Multiply stage.
   logic signed [31:0] opa [6];
   logic signed [31:0] opb [6];
   logic signed [63:0] prod_in [6];
   logic signed [63:0] prod_ff [6];
   logic signed [32:0] s33 [3];
   logic [32:0]        w33 [3];
   carry_type          c1_in;
   carry_type          c1_ff;
   logic               v1_ff;
   logic signed [31:0] av [3];
   logic signed [31:0] bv [3];

   assign av[0] = in_ff.a_x;
   assign av[1] = in_ff.a_y;
   assign av[2] = in_ff.a_z;
   assign bv[0] = in_ff.b_x;
   assign bv[1] = in_ff.b_y;
   assign bv[2] = in_ff.b_z;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         opa[k] = '0;
         opb[k] = '0;
      end
      case (in_ff.req_type)
         v3alu_pkg::OP_DOT: begin
            for (int k = 0; k < 3; k++) begin
               opa[k] = av[k];
               opb[k] = bv[k];
            end
         end
         v3alu_pkg::OP_SCALE: begin
            for (int k = 0; k < 3; k++) begin
               opa[k] = av[k];
               opb[k] = in_ff.scale_factor;
            end
         end
         v3alu_pkg::OP_CROSS: begin
            opa[0] = av[1]; opb[0] = bv[2];
            opa[1] = av[2]; opb[1] = bv[0];
            opa[2] = av[0]; opb[2] = bv[1];
            opa[3] = av[2]; opb[3] = bv[1];
            opa[4] = av[0]; opb[4] = bv[2];
            opa[5] = av[1]; opb[5] = bv[0];
         end
         v3alu_pkg::OP_LENGTH, v3alu_pkg::OP_NORMALIZE: begin
            for (int k = 0; k < 3; k++) begin
               opa[k] = av[k];
               opb[k] = av[k];
            end
         end
         default: begin
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = 64'(opa[k]) * 64'(opb[k]);
      end

      for (int k = 0; k < 3; k++) begin
         if (in_ff.req_type == v3alu_pkg::OP_SUB) begin
            s33[k] = 33'(av[k]) - 33'(bv[k]);
         end else begin
            s33[k] = 33'(av[k]) + 33'(bv[k]);
         end
         w33[k] = sat_word(66'(s33[k]));
      end

      c1_in.op = in_ff.req_type;
      for (int k = 0; k < 3; k++) begin
         c1_in.neg[k] = av[k][31];
         c1_in.mag[k] = av[k][31] ? 32'(-av[k]) : 32'(av[k]);
      end
      c1_in.rs = '0;
      if (in_ff.req_type == v3alu_pkg::OP_ADD || in_ff.req_type == v3alu_pkg::OP_SUB) begin
         c1_in.rx = w33[0][31:0];
         c1_in.ry = w33[1][31:0];
         c1_in.rz = w33[2][31:0];
         c1_in.sat = w33[0][32] | w33[1][32] | w33[2][32];
      end else begin
         c1_in.rx = '0;
         c1_in.ry = '0;
         c1_in.rz = '0;
         c1_in.sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid_ff;
      end
      if (adv) begin
         prod_ff <= prod_in;
         c1_ff <= c1_in;
      end
   end

   // Sum stage.
   logic signed [65:0] e [6];
   logic signed [65:0] sum_in [3];
   logic signed [65:0] sum_ff [3];
   logic [63:0]        sq_in;
   logic [63:0]        sq_ff;
   carry_type          c2_ff;
   logic               v2_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         e[k] = 66'(prod_ff[k]);
      end
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = '0;
      end
      case (c1_ff.op)
         v3alu_pkg::OP_DOT: begin
            sum_in[0] = e[0] + e[1] + e[2] + HALF;
         end
         v3alu_pkg::OP_SCALE: begin
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = e[k] + HALF;
            end
         end
         v3alu_pkg::OP_CROSS: begin
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = e[k] - e[k + 3] + HALF;
            end
         end
         default: begin
         end
      endcase
      sq_in = $unsigned(prod_ff[0]) + $unsigned(prod_ff[1]) + $unsigned(prod_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         c2_ff <= c1_ff;
      end
   end

   // Rounding and saturation stage, then the square root pipeline.
   logic [32:0]        sq_rem_in [SQ_STEPS + 1];
   logic [31:0]        sq_root_in [SQ_STEPS + 1];
   logic [63:0]        sq_s_in [SQ_STEPS + 1];
   carry_type          sq_c_in [SQ_STEPS + 1];
   logic [32:0]        sq_rem_ff [SQ_STEPS + 1];
   logic [31:0]        sq_root_ff [SQ_STEPS + 1];
   logic [63:0]        sq_s_ff [SQ_STEPS + 1];
   carry_type          sq_c_ff [SQ_STEPS + 1];
   logic [SQ_STEPS:0]  sq_v_ff;
   logic [32:0]        w66 [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         w66[k] = sat_word(sum_ff[k] >>> FRAC_BITS);
      end
      sq_c_in[0] = c2_ff;
      case (c2_ff.op)
         v3alu_pkg::OP_DOT: begin
            sq_c_in[0].rs = w66[0][31:0];
            sq_c_in[0].sat = w66[0][32];
         end
         v3alu_pkg::OP_SCALE, v3alu_pkg::OP_CROSS: begin
            sq_c_in[0].rx = w66[0][31:0];
            sq_c_in[0].ry = w66[1][31:0];
            sq_c_in[0].rz = w66[2][31:0];
            sq_c_in[0].sat = w66[0][32] | w66[1][32] | w66[2][32];
         end
         default: begin
         end
      endcase
      sq_rem_in[0] = '0;
      sq_root_in[0] = '0;
      sq_s_in[0] = sq_ff;
   end

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      logic [34:0] remx;
      logic [34:0] trial;
      logic        ge;
      always_comb begin
         remx = {sq_rem_ff[i], sq_s_ff[i][63:62]};
         trial = {1'b0, sq_root_ff[i], 2'b01};
         ge = remx >= trial;
         sq_rem_in[i + 1] = ge ? 33'(remx - trial) : remx[32:0];
         sq_root_in[i + 1] = {sq_root_ff[i][30:0], ge};
         sq_s_in[i + 1] = {sq_s_ff[i][61:0], 2'b00};
         sq_c_in[i + 1] = sq_c_ff[i];
      end
   end

   for (genvar i = 0; i <= SQ_STEPS; i++) begin : g_sqrt_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[i] <= (i == 0) ? v2_ff : sq_v_ff[(i == 0) ? 0 : i - 1];
         end
         if (adv) begin
            sq_rem_ff[i] <= sq_rem_in[i];
            sq_root_ff[i] <= sq_root_in[i];
            sq_s_ff[i] <= sq_s_in[i];
            sq_c_ff[i] <= sq_c_in[i];
         end
      end
   end

   // Length rounding stage.
   logic [31:0] len_in;
   logic [31:0] len_ff;
   carry_type   lc_in;
   carry_type   lc_ff;
   logic        lv_ff;

   always_comb begin
      len_in = sq_root_ff[SQ_STEPS]
             + 32'(sq_rem_ff[SQ_STEPS] > {1'b0, sq_root_ff[SQ_STEPS]});
      lc_in = sq_c_ff[SQ_STEPS];
      if (lc_in.op == v3alu_pkg::OP_LENGTH) begin
         lc_in.rs = len_in[31] ? 32'h7fffffff : len_in;
         lc_in.sat = len_in[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= 1'b0;
      end else if (adv) begin
         lv_ff <= sq_v_ff[SQ_STEPS];
      end
      if (adv) begin
         len_ff <= len_in;
         lc_ff <= lc_in;
      end
   end

   // Divider setup, then one quotient bit per stage.
   logic [2:0][31:0]   dv_rem_in [QW + 1];
   logic [2:0][QW-1:0] dv_low_in [QW + 1];
   logic [2:0][QW-1:0] dv_q_in [QW + 1];
   logic [31:0]        dv_len_in [QW + 1];
   carry_type          dv_c_in [QW + 1];
   logic [2:0][31:0]   dv_rem_ff [QW + 1];
   logic [2:0][QW-1:0] dv_low_ff [QW + 1];
   logic [2:0][QW-1:0] dv_q_ff [QW + 1];
   logic [31:0]        dv_len_ff [QW + 1];
   carry_type          dv_c_ff [QW + 1];
   logic [QW:0]        dv_v_ff;
   logic [NW-1:0]      num [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k] = (NW'(lc_ff.mag[k]) << FRAC_BITS) + NW'(len_ff >> 1);
         dv_rem_in[0][k] = num[k][NW-1:QW];
         dv_low_in[0][k] = num[k][QW-1:0];
         dv_q_in[0][k] = '0;
      end
      dv_len_in[0] = len_ff;
      dv_c_in[0] = lc_ff;
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [32:0] t [3];
      logic [2:0]  ge;
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            t[k] = {dv_rem_ff[j][k], dv_low_ff[j][k][QW-1]};
            ge[k] = t[k] >= {1'b0, dv_len_ff[j]};
            dv_rem_in[j + 1][k] = ge[k] ? 32'(t[k] - {1'b0, dv_len_ff[j]}) : t[k][31:0];
            dv_low_in[j + 1][k] = dv_low_ff[j][k] << 1;
            dv_q_in[j + 1][k] = {dv_q_ff[j][k][QW-2:0], ge[k]};
         end
         dv_len_in[j + 1] = dv_len_ff[j];
         dv_c_in[j + 1] = dv_c_ff[j];
      end
   end

   for (genvar j = 0; j <= QW; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= (j == 0) ? lv_ff : dv_v_ff[(j == 0) ? 0 : j - 1];
         end
         if (adv) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_low_ff[j] <= dv_low_in[j];
            dv_q_ff[j] <= dv_q_in[j];
            dv_len_ff[j] <= dv_len_in[j];
            dv_c_ff[j] <= dv_c_in[j];
         end
      end
   end

   // Output register.
   v3alu_pkg::v3alu_rsp_type rsp_in;
   carry_type                fc;
   logic [31:0]              nq [3];

   always_comb begin
      fc = dv_c_ff[QW];
      for (int k = 0; k < 3; k++) begin
         nq[k] = fc.neg[k] ? 32'(-32'(dv_q_ff[QW][k])) : 32'(dv_q_ff[QW][k]);
      end
      rsp_in.r_x = fc.rx;
      rsp_in.r_y = fc.ry;
      rsp_in.r_z = fc.rz;
      rsp_in.r_scalar = fc.rs;
      rsp_in.status = fc.sat ? v3alu_pkg::STATUS_SAT : v3alu_pkg::STATUS_OK;
      if (fc.op == v3alu_pkg::OP_NORMALIZE) begin
         if (dv_len_ff[QW] == '0) begin
            rsp_in.r_x = '0;
            rsp_in.r_y = '0;
            rsp_in.r_z = '0;
            rsp_in.status = v3alu_pkg::STATUS_ZERO_LEN;
         end else begin
            rsp_in.r_x = nq[0];
            rsp_in.r_y = nq[1];
            rsp_in.r_z = nq[2];
            rsp_in.status = v3alu_pkg::STATUS_OK;
         end
         rsp_in.r_scalar = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_v_ff[QW];
      end
      if (adv) begin
         out_ff <= rsp_in;
      end
   end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Vector ALU testbench
// Drives requests into the vector ALU under several idle and stall mixes,
// predicts every response with a behavioral model of the fixed-point
// arithmetic and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAC = 16;
   localparam int LATENCY = 39 + FRAC;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   v3alu_pkg::v3alu_req_type req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   v3alu_pkg::v3alu_rsp_type rsp_data;

   v3alu_pkg::v3alu_rsp_type pending_rsp[$];
   int            errors = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;
   int            quiet_cycles = 0;

   vec3_fixed_point_alu_unit #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(input logic signed [67:0] v,
                                                  inout bit sat);
      if (v > 68'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -68'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [67:0] round_grid(input logic signed [67:0] v);
      return (v + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic [67:0] root_rounded(input logic [67:0] s);
      logic [67:0] r;
      logic [67:0] cand;
      logic [67:0] rem;
      r = '0;
      for (int i = 32; i >= 0; i--) begin
         cand = r | (68'd1 << i);
         if (cand * cand <= s) r = cand;
      end
      rem = s - r * r;
      if (rem > r) r = r + 1;
      return r;
   endfunction

   function automatic logic signed [67:0] unit_component(input logic signed [67:0] c,
                                                        input logic [67:0] len);
      logic [67:0] n;
      logic [67:0] q;
      n = (c < 0 ? -c : c) << FRAC;
      q = (n + (len >> 1)) / len;
      return c < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic v3alu_pkg::v3alu_rsp_type vector_result(
         input v3alu_pkg::v3alu_req_type rq);
      v3alu_pkg::v3alu_rsp_type r;
      logic signed [67:0] ax, ay, az, bx, by, bz, sf;
      logic [67:0] s, len;
      bit sat;
      r = '0;
      sat = 1'b0;
      ax = rq.a_x; ay = rq.a_y; az = rq.a_z;
      bx = rq.b_x; by = rq.b_y; bz = rq.b_z;
      sf = rq.scale_factor;
      case (rq.req_type)
         v3alu_pkg::OP_ADD: begin
            r.r_x = clamp32(ax + bx, sat);
            r.r_y = clamp32(ay + by, sat);
            r.r_z = clamp32(az + bz, sat);
         end
         v3alu_pkg::OP_SUB: begin
            r.r_x = clamp32(ax - bx, sat);
            r.r_y = clamp32(ay - by, sat);
            r.r_z = clamp32(az - bz, sat);
         end
         v3alu_pkg::OP_DOT: begin
            r.r_scalar = clamp32(round_grid(ax * bx + ay * by + az * bz), sat);
         end
         v3alu_pkg::OP_SCALE: begin
            r.r_x = clamp32(round_grid(ax * sf), sat);
            r.r_y = clamp32(round_grid(ay * sf), sat);
            r.r_z = clamp32(round_grid(az * sf), sat);
         end
         v3alu_pkg::OP_CROSS: begin
            r.r_x = clamp32(round_grid(ay * bz - az * by), sat);
            r.r_y = clamp32(round_grid(az * bx - ax * bz), sat);
            r.r_z = clamp32(round_grid(ax * by - ay * bx), sat);
         end
         v3alu_pkg::OP_LENGTH, v3alu_pkg::OP_NORMALIZE: begin
            s = ax * ax + ay * ay + az * az;
            len = root_rounded(s);
            if (rq.req_type == v3alu_pkg::OP_LENGTH) begin
               r.r_scalar = clamp32($signed(len), sat);
            end else if (len == 0) begin
               r.status = v3alu_pkg::STATUS_ZERO_LEN;
            end else begin
               r.r_x = clamp32(unit_component(ax, len), sat);
               r.r_y = clamp32(unit_component(ay, len), sat);
               r.r_z = clamp32(unit_component(az, len), sat);
            end
         end
         default: ;
      endcase
      if (r.status == v3alu_pkg::STATUS_OK && sat) r.status = v3alu_pkg::STATUS_SAT;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: mismatch %s got %h want %h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      v3alu_pkg::v3alu_rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
         if (req_valid && req_ready) pending_rsp.push_back(vector_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.r_x, 32'h0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.r_x !== want.r_x) report_mismatch("r_x", rsp_data.r_x, want.r_x);
               if (rsp_data.r_y !== want.r_y) report_mismatch("r_y", rsp_data.r_y, want.r_y);
               if (rsp_data.r_z !== want.r_z) report_mismatch("r_z", rsp_data.r_z, want.r_z);
               if (rsp_data.r_scalar !== want.r_scalar)
                  report_mismatch("r_scalar", rsp_data.r_scalar, want.r_scalar);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input v3alu_pkg::v3alu_req_type rq);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = rq;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(6))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3: return $urandom_range(262143) - 131072;
         4: return $signed($urandom) >>> $urandom_range(24);
         default: return $urandom;
      endcase
   endfunction

   function automatic v3alu_pkg::v3alu_req_type random_request();
      v3alu_pkg::v3alu_req_type rq;
      rq.req_type = ($urandom_range(19) == 0) ? OP_UNUSED : 3'($urandom_range(6));
      rq.a_x = pick_word(); rq.a_y = pick_word(); rq.a_z = pick_word();
      rq.b_x = pick_word(); rq.b_y = pick_word(); rq.b_z = pick_word();
      rq.scale_factor = pick_word();
      if (rq.req_type == v3alu_pkg::OP_NORMALIZE && $urandom_range(9) == 0) begin
         rq.a_x = 0; rq.a_y = 0; rq.a_z = 0;
      end
      return rq;
   endfunction

   function automatic v3alu_pkg::v3alu_req_type make_request(input logic [2:0] op,
                                                  input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] sf);
      v3alu_pkg::v3alu_req_type rq;
      rq.req_type = op;
      rq.a_x = a; rq.a_y = a; rq.a_z = a;
      rq.b_x = b; rq.b_y = b; rq.b_z = b;
      rq.scale_factor = sf;
      return rq;
   endfunction

   task automatic test_directed();
      logic [2:0] op;
      idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i <= 7; i++) begin
         op = 3'(i);
         send_request(make_request(op, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
         send_request(make_request(op, 32'h80000000, 32'h7fffffff, 32'h80000000));
         send_request(make_request(op, 32'h00010000, 32'hffff8000, 32'h00008000));
      end
      send_request(make_request(v3alu_pkg::OP_NORMALIZE, 32'h0, 32'h0, 32'h0));
      wait_drained();
   endtask

   task automatic test_random(input int n, input int idle, input int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 20; i++) send_request(random_request());
      wait_drained();
      for (int i = 0; i < 20; i++) send_request(random_request());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(500, 0, 0);
      test_random(500, 57, 0);
      test_random(500, 0, 57);
      test_random(500, 12, 12);
      test_pause_until_drained();
      wait_drained();
      repeat (LATENCY + 20) @(negedge clock);
      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
